FILE: rtl/core/rational_arith_unit_assert.svh
// assertion macros for the checker file
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/rau_pkg.sv
`default_nettype none
package rau_pkg;
	localparam int WORD_BITS = 32;
	localparam int WIDE_BITS = 2 * WORD_BITS + 1;
	localparam int WCNT_BITS = $clog2(WIDE_BITS + 1);

	typedef enum logic [2:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_MUL = 3'd2,
		KIND_DIV = 3'd3,
		KIND_TRUNC = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// one classified item passed from front to back
	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] status;
		logic a_neg;
		logic [WORD_BITS-1:0] a_num;
		logic ad_neg;
		logic [WORD_BITS-1:0] a_den;
		logic b_neg;
		logic [WORD_BITS-1:0] b_num;
		logic bd_neg;
		logic [WORD_BITS-1:0] b_den;
	} item_t;

	// magnitude of a word taken from its low WORD_BITS bits
	function automatic logic [WORD_BITS-1:0] mag_of(input logic [31:0] raw);
		logic [WORD_BITS-1:0] v;
		v = raw[WORD_BITS-1:0];
		return v[WORD_BITS-1] ? (~v + 1'b1) : v;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/rau_front.sv
`default_nettype none
// accepts commands, takes operand magnitudes and flags bad denominators, unknown kinds and divide by zero
module rau_front (
	input wire logic start,
	output logic busy,
	input wire logic [2:0] kind,
	input wire logic signed [31:0] a_num,
	input wire logic signed [31:0] a_den,
	input wire logic signed [31:0] b_num,
	input wire logic signed [31:0] b_den,
	output logic q_push,
	output rau_pkg::item_t q_item,
	input wire logic q_full
);
	logic [rau_pkg::WORD_BITS-1:0] am, adm, bm, bdm;
	logic bad;

	assign busy = q_full;
	assign q_push = start && !q_full;
	assign am = rau_pkg::mag_of(a_num);
	assign adm = rau_pkg::mag_of(a_den);
	assign bm = rau_pkg::mag_of(b_num);
	assign bdm = rau_pkg::mag_of(b_den);

	// classification of illegal commands
	always_comb begin
		bad = 1'b0;
		if (kind > rau_pkg::KIND_TRUNC || adm == '0) begin
			bad = 1'b1;
		end else if (kind != rau_pkg::KIND_TRUNC && bdm == '0) begin
			bad = 1'b1;
		end else if (kind == rau_pkg::KIND_DIV && bm == '0) begin
			bad = 1'b1;
		end
	end

	// item packing
	always_comb begin
		q_item.kind = kind;
		q_item.status = bad ? rau_pkg::ST_ZERO_DEN : rau_pkg::ST_OK;
		q_item.a_num = am;
		q_item.a_neg = (am != '0) && a_num[rau_pkg::WORD_BITS-1];
		q_item.a_den = adm;
		q_item.ad_neg = a_den[rau_pkg::WORD_BITS-1];
		q_item.b_num = bm;
		q_item.b_neg = (bm != '0) && b_num[rau_pkg::WORD_BITS-1];
		q_item.b_den = bdm;
		q_item.bd_neg = b_den[rau_pkg::WORD_BITS-1];
	end
endmodule
`default_nettype wire

FILE: rtl/core/rau_queue.sv
`default_nettype none
// two-entry queue between front and back
module rau_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire rau_pkg::item_t push_item,
	output logic full,
	input wire logic pop,
	output logic not_empty,
	output rau_pkg::item_t pop_item
);
	rau_pkg::item_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_item = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end
endmodule
`default_nettype wire

FILE: rtl/core/rau_back.sv
`default_nettype none
// executes one item: products, sum, binary gcd, serial divides, range check
module rau_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	input wire rau_pkg::item_t q_item,
	output logic q_pop,
	output logic done,
	output logic signed [31:0] res_num,
	output logic [30:0] res_den,
	output logic [1:0] status
);
	localparam int W = rau_pkg::WORD_BITS;
	localparam int X = rau_pkg::WIDE_BITS;
	localparam int C = rau_pkg::WCNT_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_SUM, S_GCD, S_DIVN, S_DIVD, S_CHECK, S_OUT
	} state_t;

	state_t state_q;
	rau_pkg::item_t it_q;
	logic [X-1:0] p0_q, nmag_q, dmag_q, gx_q, gy_q, g_q, rem_q, dvd_q;
	logic p0_neg_q, neg_q, dd_neg_q;
	logic [C-1:0] sh_q, bit_q;
	logic [1:0] st_q;
	logic [2*W-1:0] prod;
	logic [W-1:0] m_x, m_y;
	logic [X:0] rtry;
	logic [X-1:0] limit;

	assign limit = X'(1) << (W - 1);
	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign prod = m_x * m_y;
	assign rtry = {rem_q, dvd_q[X-1]} - {1'b0, g_q};

	// multiplier operand select
	always_comb begin
		m_x = it_q.a_num;
		m_y = it_q.b_den;
		if (state_q == S_MUL1) begin
			if (it_q.kind == rau_pkg::KIND_MUL) m_y = it_q.b_num;
		end else begin
			m_x = it_q.a_den;
			m_y = (it_q.kind == rau_pkg::KIND_DIV) ? it_q.b_num : it_q.b_den;
			if (state_q == S_SUM) m_y = it_q.b_num;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
			res_num <= '0;
			res_den <= '0;
			status <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						it_q <= q_item;
						st_q <= q_item.status;
						if (q_item.status != rau_pkg::ST_OK) begin
							state_q <= S_OUT;
						end else if (q_item.kind == rau_pkg::KIND_TRUNC) begin
							// trunc: numerator quotient by a_den via divider
							nmag_q <= X'(q_item.a_num);
							dmag_q <= X'(1);
							g_q <= X'(q_item.a_den);
							neg_q <= q_item.a_neg != q_item.ad_neg;
							dvd_q <= X'(q_item.a_num);
							rem_q <= '0;
							bit_q <= '0;
							state_q <= S_DIVN;
						end else begin
							state_q <= S_MUL1;
						end
					end
				end
				S_MUL1: begin
					p0_q <= X'(prod);
					p0_neg_q <= it_q.a_neg != (it_q.kind == rau_pkg::KIND_MUL ?
						it_q.b_neg : it_q.bd_neg);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					// denominator product
					dmag_q <= X'(prod);
					dd_neg_q <= it_q.ad_neg != ((it_q.kind == rau_pkg::KIND_DIV) ?
						it_q.b_neg : it_q.bd_neg);
					if (it_q.kind == rau_pkg::KIND_ADD || it_q.kind == rau_pkg::KIND_SUB)
						state_q <= S_SUM;
					else begin
						nmag_q <= p0_q;
						neg_q <= p0_neg_q;
						state_q <= S_GCD;
						gx_q <= p0_q;
						gy_q <= X'(prod);
						sh_q <= '0;
					end
				end
				S_SUM: begin
					logic bn;
					logic [X-1:0] s;
					logic sn;
					bn = it_q.ad_neg != (it_q.b_neg != (it_q.kind == rau_pkg::KIND_SUB &&
						it_q.b_num != '0));
					if (p0_neg_q == bn) begin
						s = p0_q + X'(prod);
						sn = p0_neg_q;
					end else if (p0_q >= X'(prod)) begin
						s = p0_q - X'(prod);
						sn = p0_neg_q;
					end else begin
						s = X'(prod) - p0_q;
						sn = bn;
					end
					nmag_q <= s;
					neg_q <= sn;
					gx_q <= s;
					gy_q <= dmag_q;
					sh_q <= '0;
					state_q <= S_GCD;
				end
				S_GCD: begin
					// binary gcd, one step per cycle
					if (gx_q == '0) begin
						// numerator zero: result is 0/1
						neg_q <= 1'b0;
						nmag_q <= '0;
						dmag_q <= X'(1);
						state_q <= S_CHECK;
					end else if (gx_q == gy_q) begin
						g_q <= gx_q << sh_q;
						dvd_q <= nmag_q;
						rem_q <= '0;
						bit_q <= '0;
						neg_q <= neg_q != dd_neg_q;
						state_q <= S_DIVN;
					end else if (!gx_q[0] && !gy_q[0]) begin
						gx_q <= gx_q >> 1;
						gy_q <= gy_q >> 1;
						sh_q <= sh_q + 1'b1;
					end else if (!gx_q[0]) begin
						gx_q <= gx_q >> 1;
					end else if (!gy_q[0]) begin
						gy_q <= gy_q >> 1;
					end else if (gx_q > gy_q) begin
						gx_q <= (gx_q - gy_q) >> 1;
					end else begin
						gy_q <= (gy_q - gx_q) >> 1;
					end
				end
				S_DIVN, S_DIVD: begin
					// restoring divide, one quotient bit per cycle
					logic qb;
					logic [X-1:0] nr;
					qb = !rtry[X];
					nr = qb ? rtry[X-1:0] : {rem_q[X-2:0], dvd_q[X-1]};
					rem_q <= nr;
					dvd_q <= {dvd_q[X-2:0], qb};
					bit_q <= bit_q + 1'b1;
					if (bit_q == C'(X - 1)) begin
						rem_q <= '0;
						bit_q <= '0;
						if (state_q == S_DIVN) begin
							nmag_q <= {dvd_q[X-2:0], qb};
							if (it_q.kind == rau_pkg::KIND_TRUNC) begin
								state_q <= S_CHECK;
							end else begin
								dvd_q <= dmag_q;
								state_q <= S_DIVD;
							end
						end else begin
							dmag_q <= {dvd_q[X-2:0], qb};
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (nmag_q == '0) neg_q <= 1'b0;
					if ((neg_q && nmag_q != '0 ? nmag_q > limit : nmag_q > limit - 1'b1)
						|| dmag_q > limit - 1'b1)
						st_q <= rau_pkg::ST_RANGE;
					state_q <= S_OUT;
				end
				S_OUT: begin
					done <= 1'b1;
					status <= st_q;
					if (st_q == rau_pkg::ST_OK) begin
						res_num <= neg_q ? 32'(-nmag_q) : 32'(nmag_q);
						res_den <= 31'(dmag_q);
					end else begin
						res_num <= '0;
						res_den <= 31'd1;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/rational_arith_unit.sv
// rational_arith_unit: exact add, subtract, multiply, divide and truncate on
// fractions of 32-bit signed integers, reduced to lowest terms.
// channels: a command is transferred when start is high and busy is low;
// kind, a_num, a_den, b_num, b_den are sampled at that edge.
// results appear on res_num, res_den and status for one cycle with done high;
// the receiver cannot stall and must take each result as it appears.
// error commands go straight to the result; truncate uses only the divider;
// other kinds run the products, the one-step binary gcd and two passes of
// the one-bit-per-cycle restoring divider in the back end.
// a two-entry command queue lets two further commands be taken while one runs.
// reset clears the queue and the sequencer; no result is pending after it.
// bad denominators, divide by zero and unknown kinds give status 1, 0/1;
// results beyond word range give status 2, 0/1.
`default_nettype none
module rational_arith_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [2:0] kind,
	input wire logic signed [31:0] a_num,
	input wire logic signed [31:0] a_den,
	input wire logic signed [31:0] b_num,
	input wire logic signed [31:0] b_den,
	output logic done,
	output logic signed [31:0] res_num,
	output logic [30:0] res_den,
	output logic [1:0] status
);
	logic push, full, pop, nonempty;
	rau_pkg::item_t in_item, out_item;

	rau_front u_front (.start, .busy, .kind, .a_num, .a_den, .b_num,
		.b_den, .q_push(push), .q_item(in_item), .q_full(full));

	rau_queue u_queue (.clk, .arst_n, .push, .push_item(in_item), .full, .pop,
		.not_empty(nonempty), .pop_item(out_item));

	rau_back u_back (.clk, .arst_n, .q_valid(nonempty), .q_item(out_item), .q_pop(pop),
		.done, .res_num, .res_den, .status);
endmodule
`default_nettype wire

FILE: rtl/core/rau_checker.sv
`default_nettype none
`include "rational_arith_unit_assert.svh"
// port-level checks on results
module rau_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic done,
	input wire logic signed [31:0] res_num,
	input wire logic [30:0] res_den,
	input wire logic [1:0] status
);
	`RAU_ASSERT_IMP(a_err_zero, clk, arst_n, done && status != rau_pkg::ST_OK,
		res_num == 0 && res_den == 31'd1, "error result not 0/1")
	`RAU_ASSERT_IMP(a_den_pos, clk, arst_n, done, res_den != 31'd0, "zero denominator")
	`RAU_ASSERT_IMP(a_zero_one, clk, arst_n, done && res_num == 0, res_den == 31'd1,
		"zero not 0/1")
	`RAU_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "back to back results")
endmodule

bind rational_arith_unit rau_checker u_chk (.clk, .arst_n, .done, .res_num, .res_den,
	.status);
`default_nettype wire
